FILE: rtl/spqs_pkg.sv
// shared types, constants and the ordering function of the priority queue scheduler
`default_nettype none

package spqs_pkg;

  localparam int unsigned CAPACITY_DEF  = 1024;
  localparam int unsigned TAG_BITS      = 16;
  localparam int unsigned SEVERITY_BITS = 8;
  localparam int unsigned ARRIVAL_BITS  = 32;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_SERVE  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_SERVED   = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_DN_LOAD,
    S_DN_TOP,
    S_DN_RD,
    S_DN_CMP,
    S_PUT,
    S_EMIT
  } state_e;

  typedef struct packed {
    op_e                      operation;
    logic [TAG_BITS-1:0]      entry_tag;
    logic [SEVERITY_BITS-1:0] severity;
  } req_t;

  typedef struct packed {
    logic [TAG_BITS-1:0]      served_tag;
    logic [SEVERITY_BITS-1:0] served_severity;
    status_e                  status;
  } rsp_t;

  typedef struct packed {
    logic [TAG_BITS-1:0]      tag;
    logic [SEVERITY_BITS-1:0] sev;
    logic [ARRIVAL_BITS-1:0]  arrival;
  } slot_t;

  // higher severity wins, equal severity goes to the earlier arrival
  function automatic logic outranks(slot_t x, slot_t y);
    if (x.sev != y.sev) begin
      return x.sev > y.sev;
    end
    return x.arrival < y.arrival;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/stable_priority_queue_scheduler.sv
// binary max-heap priority queue with fifo order among equal severities
//
//  channel | dir | handshake               | payload
//  --------+-----+-------------------------+---------------------------------------
//  request | in  | in_valid_i / in_ready_o | in_data_i  (operation, tag, severity)
//  result  | out | out_valid_o/ out_ready_i| out_data_o (tag, severity, status)
//
// one request at a time, from the accepting cycle through the emit step: insert climbs
// a level per read and compare step, then writes the item in the put step, going straight
// to put when the queue was empty; serve reads the root and last entry, then descends a
// level per read and compare step, skipping the descent for the only entry; each level is
// one read-compare-write pass over the heap memory's two read ports and one write port.
// full and empty requests go straight to the emit step. reset clears the state, the
// entry count, arrival counter and output valid; the heap memory needs no clearing.
// a stalled result beat holds in the output register while the next request is already taken.
`default_nettype none

module stable_priority_queue_scheduler
  import spqs_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire req_t in_data_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output rsp_t      out_data_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  state_e                  state_q, state_d;
  logic [CW-1:0]           count_q, count_d;
  logic [ARRIVAL_BITS-1:0] arr_q, arr_d;
  logic [AW-1:0]           hole_q, hole_d;
  slot_t                   item_q, item_d;
  rsp_t                    res_q, res_d;
  rsp_t                    out_q, out_d;
  logic                    out_valid_q, out_valid_d;

  // heap memory, one write and two registered reads per cycle
  slot_t         mem [CAPACITY];
  logic          mem_we;
  logic [AW-1:0] mem_wa, mem_ra_a, mem_ra_b;
  slot_t         mem_wd, rd_a_q, rd_b_q;

  logic [AW-1:0] parent_w;
  logic [CW:0]   left_w, right_w;
  logic          left_ok, right_ok, full_w, pick_left, pick_right;
  slot_t         cand_w;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_a_q <= mem[mem_ra_a];
    rd_b_q <= mem[mem_ra_b];
  end

  assign parent_w = (hole_q - AW'(1)) >> 1;
  assign left_w   = (CW + 1)'({hole_q, 1'b1});
  assign right_w  = left_w + (CW + 1)'(1);
  assign left_ok  = left_w < {1'b0, count_q};
  assign right_ok = right_w < {1'b0, count_q};
  assign full_w   = count_q == CW'(CAPACITY);

  assign pick_left  = outranks(rd_a_q, item_q);
  assign cand_w     = pick_left ? rd_a_q : item_q;
  assign pick_right = right_ok && outranks(rd_b_q, cand_w);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    arr_d       = arr_q;
    hole_d      = hole_q;
    item_d      = item_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready_o  = 1'b0;
    mem_we      = 1'b0;
    mem_wa      = hole_q;
    mem_wd      = item_q;
    mem_ra_a    = '0;
    mem_ra_b    = '0;

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          res_d = '{served_tag: '0, served_severity: '0, status: ST_INSERTED};
          if (in_data_i.operation == OP_INSERT) begin
            if (full_w) begin
              res_d.status = ST_FULL;
              state_d      = S_EMIT;
            end else begin
              item_d  = '{tag: in_data_i.entry_tag, sev: in_data_i.severity, arrival: arr_q};
              hole_d  = count_q[AW-1:0];
              count_d = count_q + CW'(1);
              arr_d   = arr_q + ARRIVAL_BITS'(1);
              state_d = (count_q == '0) ? S_PUT : S_UP_RD;
            end
          end else begin
            if (count_q == '0) begin
              res_d.status = ST_EMPTY;
              state_d      = S_EMIT;
            end else begin
              count_d = count_q - CW'(1);
              state_d = S_DN_LOAD;
            end
          end
        end
      end
      S_UP_RD: begin
        mem_ra_a = parent_w;
        state_d  = S_UP_CMP;
      end
      S_UP_CMP: begin
        if (outranks(item_q, rd_a_q)) begin
          // parent moves down into the hole
          mem_we  = 1'b1;
          mem_wd  = rd_a_q;
          hole_d  = parent_w;
          state_d = (parent_w == '0) ? S_PUT : S_UP_RD;
        end else begin
          state_d = S_PUT;
        end
      end
      S_DN_LOAD: begin
        mem_ra_a = '0;
        mem_ra_b = count_q[AW-1:0];
        state_d  = S_DN_TOP;
      end
      S_DN_TOP: begin
        res_d   = '{served_tag: rd_a_q.tag, served_severity: rd_a_q.sev, status: ST_SERVED};
        item_d  = rd_b_q;
        hole_d  = '0;
        state_d = (count_q == '0) ? S_EMIT : S_DN_RD;
      end
      S_DN_RD: begin
        mem_ra_a = left_w[AW-1:0];
        mem_ra_b = right_w[AW-1:0];
        state_d  = left_ok ? S_DN_CMP : S_PUT;
      end
      S_DN_CMP: begin
        if (pick_right) begin
          mem_we  = 1'b1;
          mem_wd  = rd_b_q;
          hole_d  = right_w[AW-1:0];
          state_d = S_DN_RD;
        end else if (pick_left) begin
          mem_we  = 1'b1;
          mem_wd  = rd_a_q;
          hole_d  = left_w[AW-1:0];
          state_d = S_DN_RD;
        end else begin
          state_d = S_PUT;
        end
      end
      S_PUT: begin
        mem_we  = 1'b1;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      arr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      arr_q       <= arr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hole_q <= hole_d;
    item_q <= item_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_write_live : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (CW'(mem_wa) < count_q))
    else $error("heap write outside the live entries");

  a_insert_grows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_data_i.operation == OP_INSERT && !full_w)
    |=> (count_q == $past(count_q) + CW'(1)))
    else $error("insert did not add an entry");

  a_serve_shrinks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_data_i.operation == OP_SERVE && count_q != '0)
    |=> (count_q == $past(count_q) - CW'(1)))
    else $error("serve did not remove an entry");

  a_beat_from_emit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !$past(out_valid_q)) |-> $past(state_q == S_EMIT))
    else $error("result beat raised outside the emit step");

endmodule

`default_nettype wire

FILE: test/stable_priority_queue_scheduler_tb.sv
// testbench for the stable priority queue scheduler: heap predictor, directed and random traffic
`timescale 1ns / 1ps

module stable_priority_queue_scheduler_tb;
  import spqs_pkg::*;

  localparam int unsigned QCAP = CAPACITY_DEF;
  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned SETTLE_CYCLES = 80;

  typedef struct {
    req_t req;
    bit   wait_idle;
  } req_item_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  req_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  rsp_t out_data_o;

  req_item_t   request_backlog[$];
  rsp_t        expected_results[$];
  int unsigned accepted_cnt = 0;
  int unsigned presented_cnt = 0;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;

  // predictor state: heap of queued entries plus the arrival stamp
  slot_t       model_heap[QCAP];
  int unsigned model_level = 0;
  logic [ARRIVAL_BITS-1:0] model_arrival_next = '0;

  // occupancy seen while building traffic, used to reach the full queue
  int unsigned planned_level = 0;

  stable_priority_queue_scheduler #(
    .CAPACITY(QCAP)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic bit ahead_of(slot_t a, slot_t b);
    if (a.sev != b.sev) begin
      return a.sev > b.sev;
    end
    return a.arrival < b.arrival;
  endfunction

  function automatic rsp_t heap_model_step(req_t req);
    rsp_t  r;
    slot_t t;
    int    pos;
    int    parent;
    int    left;
    int    right;
    int    best;
    r = '0;
    if (req.operation == OP_INSERT) begin
      if (model_level >= QCAP) begin
        r.status = ST_FULL;
      end else begin
        pos = model_level;
        model_heap[pos].tag = req.entry_tag;
        model_heap[pos].sev = req.severity;
        model_heap[pos].arrival = model_arrival_next;
        model_level++;
        model_arrival_next++;
        while (pos > 0) begin
          parent = (pos - 1) / 2;
          if (!ahead_of(model_heap[pos], model_heap[parent])) break;
          t = model_heap[pos];
          model_heap[pos] = model_heap[parent];
          model_heap[parent] = t;
          pos = parent;
        end
        r.status = ST_INSERTED;
      end
    end else begin
      if (model_level == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.served_tag = model_heap[0].tag;
        r.served_severity = model_heap[0].sev;
        model_level--;
        if (model_level > 0) begin
          model_heap[0] = model_heap[model_level];
          pos = 0;
          while (1) begin
            left = 2 * pos + 1;
            right = left + 1;
            best = pos;
            if (left < model_level && ahead_of(model_heap[left], model_heap[best])) best = left;
            if (right < model_level && ahead_of(model_heap[right], model_heap[best])) best = right;
            if (best == pos) break;
            t = model_heap[pos];
            model_heap[pos] = model_heap[best];
            model_heap[best] = t;
            pos = best;
          end
        end
        r.status = ST_SERVED;
      end
    end
    return r;
  endfunction

  task automatic queue_request(op_e op, logic [TAG_BITS-1:0] tag,
                               logic [SEVERITY_BITS-1:0] sev, bit wait_idle = 1'b0);
    req_item_t it;
    it.req.operation = op;
    it.req.entry_tag = tag;
    it.req.severity = sev;
    it.wait_idle = wait_idle;
    request_backlog.push_back(it);
    if (op == OP_INSERT && planned_level < QCAP) planned_level++;
    if (op == OP_SERVE && planned_level > 0) planned_level--;
  endtask

  // mix of full range, extremes and a narrow band that forces ties
  function automatic logic [SEVERITY_BITS-1:0] pick_severity();
    case ($urandom_range(0, 3))
      0: begin
        case ($urandom_range(0, 3))
          0: return '0;
          1: return '1;
          2: return 8'h80;
          default: return 8'h01;
        endcase
      end
      1: return SEVERITY_BITS'($urandom_range(60, 63));
      default: return SEVERITY_BITS'($urandom);
    endcase
  endfunction

  task automatic queue_mixed(int unsigned count, int unsigned serve_pct);
    for (int unsigned i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < serve_pct) begin
        queue_request(OP_SERVE, TAG_BITS'($urandom), SEVERITY_BITS'($urandom));
      end else begin
        queue_request(OP_INSERT, TAG_BITS'($urandom), pick_severity());
      end
    end
  endtask

  task automatic build_traffic();
    // directed: empty serve, extremes, fifo order among equal severities
    queue_request(OP_SERVE, 16'hffff, 8'hff);
    queue_request(OP_INSERT, 16'h0000, 8'h00);
    queue_request(OP_INSERT, 16'hffff, 8'hff);
    for (int i = 1; i <= 4; i++) begin
      queue_request(OP_INSERT, TAG_BITS'(i), 8'h80);
    end
    queue_request(OP_INSERT, 16'h0005, 8'h81);
    queue_request(OP_INSERT, 16'h0006, 8'h80);
    for (int i = 0; i < 9; i++) begin
      queue_request(OP_SERVE, TAG_BITS'($urandom), SEVERITY_BITS'($urandom));
    end
    queue_request(OP_INSERT, 16'ha5a5, 8'h5a);
    queue_request(OP_INSERT, 16'h5a5a, 8'ha5);
    queue_request(OP_SERVE, 16'h0000, 8'h00);
    queue_request(OP_SERVE, 16'h0000, 8'h00);
    queue_request(OP_SERVE, 16'h0000, 8'h00);

    queue_mixed(300, 50);

    // fill up to capacity after the pipeline drains, then knock on a full queue
    queue_request(OP_INSERT, TAG_BITS'($urandom), pick_severity(), 1'b1);
    while (planned_level < QCAP) begin
      queue_request(OP_INSERT, TAG_BITS'($urandom), pick_severity());
    end
    queue_request(OP_INSERT, 16'hffff, 8'hff);
    queue_request(OP_INSERT, 16'h0000, 8'h00);
    for (int i = 0; i < 4; i++) begin
      queue_request(OP_INSERT, TAG_BITS'($urandom), pick_severity());
    end

    queue_request(OP_SERVE, TAG_BITS'($urandom), SEVERITY_BITS'($urandom), 1'b1);
    queue_mixed(560, 75);
  endtask

  // sender: bursts of random length separated by random gaps
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  always @(negedge clk_i) begin
    req_item_t it;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (in_valid_i && accepted_cnt != presented_cnt) begin
      // beat still waiting for ready
    end else if (gap_left > 0) begin
      gap_left--;
      in_valid_i <= 1'b0;
    end else if (request_backlog.size() == 0 ||
                 (request_backlog[0].wait_idle && expected_results.size() != 0)) begin
      in_valid_i <= 1'b0;
    end else begin
      it = request_backlog.pop_front();
      in_data_i <= it.req;
      in_valid_i <= 1'b1;
      presented_cnt++;
      if (burst_left <= 1) begin
        burst_left = $urandom_range(1, 40);
        gap_left = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
      end else begin
        burst_left--;
      end
    end
  end

  // receiver: stall style picked at random, changed after a random span
  int unsigned rx_mode = 0;
  int unsigned rx_span = 0;
  int unsigned rx_tick = 0;

  always @(negedge clk_i) begin
    if (rx_span == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_span = $urandom_range(20, 200);
    end else begin
      rx_span--;
    end
    rx_tick++;
    case (rx_mode)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= 1'($urandom_range(0, 1));
      2: out_ready_i <= ($urandom_range(0, 3) == 0);
      default: out_ready_i <= rx_tick[2];
    endcase
  end

  always @(posedge clk_i) begin
    rsp_t want;
    bit   moved;
    moved = 1'b0;
    if (in_valid_i && in_ready_o) begin
      expected_results.push_back(heap_model_step(in_data_i));
      accepted_cnt <= accepted_cnt + 1;
      moved = 1'b1;
    end
    if (out_valid_o && out_ready_i) begin
      moved = 1'b1;
      if (expected_results.size() == 0) begin
        $error("result beat with no request outstanding: %h", out_data_o);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (out_data_o.served_tag !== want.served_tag) begin
          $error("served_tag: expected %h, got %h", want.served_tag, out_data_o.served_tag);
          mismatches++;
        end
        if (out_data_o.served_severity !== want.served_severity) begin
          $error("served_severity: expected %h, got %h",
                 want.served_severity, out_data_o.served_severity);
          mismatches++;
        end
        if (out_data_o.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data_o.status);
          mismatches++;
        end
      end
    end
    quiet_cycles = moved ? 0 : quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    build_traffic();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    while (request_backlog.size() != 0 || accepted_cnt != presented_cnt ||
           expected_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
